/* hw/rtl/nqrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqrf_pkg
// Shared widths, codes and control types of the Newton quadratic root finder.
// ----------------------------------------------------------------------------
package nqrf_pkg;

    localparam int XW        = 32;   // Q16.16 estimate
    localparam int ITER_W    = 8;
    localparam int STAT_W    = 2;
    localparam int TOL_W     = 31;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 32;
    localparam int QUO_W     = 34;   // quotient bits resolved by the divider
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int RES_W     = XW + ITER_W + STAT_W;

    localparam int MAX_ITER_LIMIT_DEF = 255;

    localparam logic [TOL_W-1:0]  TOL_RESET      = 31'd66;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'b1;

    localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STAT_W-1:0] ST_DERIV_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd2;

    typedef struct packed {
        logic load;       // take the starting guess
        logic mul;        // square the estimate
        logic fx;         // form f(x), f'(x) magnitudes
        logic sat_chk;    // check for quotient overflow, preset quotient (all ones on overflow, else zero)
        logic div_step;   // one restoring division step
        logic upd;        // form saturated x_next
        logic commit;     // x <= x_next
        logic sel_xn;     // result comes from x_next
    } cmd_t;

    typedef struct packed {
        logic deriv_zero;
        logic quo_sat;
        logic step_small;
    } sts_t;

endpackage

/* hw/rtl/nqrf_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqrf_cfg
// Configuration registers: convergence tolerance and iteration limit.
// ----------------------------------------------------------------------------
module nqrf_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nqrf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nqrf_pkg::CFG_DW-1:0]         cfg_data,
    output logic [nqrf_pkg::TOL_W-1:0]          tolerance,
    output logic [nqrf_pkg::ITER_W-1:0]         max_iterations
);

    logic [nqrf_pkg::TOL_W-1:0]  tol_reg;
    logic [nqrf_pkg::ITER_W-1:0] max_iter_reg;

    assign cfg_ready      = 1'b1;
    assign tolerance      = tol_reg;
    assign max_iterations = max_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg      <= nqrf_pkg::TOL_RESET;
            max_iter_reg <= nqrf_pkg::MAX_ITER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                nqrf_pkg::CFG_TOLERANCE: tol_reg <= cfg_data[nqrf_pkg::TOL_W-1:0];
                nqrf_pkg::CFG_MAX_ITER:  max_iter_reg <= cfg_data[nqrf_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/nqrf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqrf_dp
// Newton step datapath: squarer, f/f' formation, restoring divider,
// saturating update and step-size compare.
// ----------------------------------------------------------------------------
module nqrf_dp (
    input  logic                                aclk,
    input  logic signed [nqrf_pkg::XW-1:0]      in_guess,
    input  logic [nqrf_pkg::TOL_W-1:0]          tolerance,
    input  nqrf_pkg::cmd_t                      cmd,
    output nqrf_pkg::sts_t                      sts,
    output logic signed [nqrf_pkg::XW-1:0]      root
);

    localparam int XW   = nqrf_pkg::XW;
    localparam int QW   = nqrf_pkg::QUO_W;
    localparam int SQW  = 2 * XW;        // x*x, f(x)
    localparam int FPW  = XW + 2;        // f'(x) signed
    localparam int DENW = FPW - 1 + QW - 1;

    logic signed [XW-1:0]   x_reg, xn_reg;
    logic signed [SQW-1:0]  sq_reg;
    logic [SQW-1:0]         rem_reg;
    logic [DENW-1:0]        den_reg;
    logic [QW-1:0]          q_reg;
    logic                   qneg_reg;

    logic signed [SQW-1:0]  fx;
    logic [SQW-1:0]         fx_mag;
    logic signed [FPW-1:0]  fpx;
    logic [FPW-2:0]         fpx_mag;
    logic                   div_ge;
    logic signed [QW+1:0]   q_signed;
    logic signed [QW+1:0]   diff;
    logic signed [XW-1:0]   xn_next;
    logic signed [XW:0]     step_d;
    logic [XW:0]            step_mag;

    always_comb begin
        fx = sq_reg - ($signed({{XW{x_reg[XW-1]}}, x_reg}) <<< 16)
             - $signed(SQW'(64'h2_0000_0000));
        fx_mag = fx[SQW-1] ? SQW'(-fx) : SQW'(fx);
        fpx = $signed({x_reg[XW-1], x_reg, 1'b0}) - $signed(FPW'(32'h1_0000));
        fpx_mag = fpx[FPW-1] ? (FPW-1)'(-fpx) : (FPW-1)'(fpx);

        div_ge = {2'b00, rem_reg} >= den_reg;

        q_signed = qneg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        diff = $signed({{(QW+2-XW){x_reg[XW-1]}}, x_reg}) - q_signed;
        if (diff > $signed((QW+2)'(32'h7FFF_FFFF))) begin
            xn_next = $signed(32'h7FFF_FFFF);
        end else if (diff < -$signed((QW+2)'(33'h0_8000_0000))) begin
            xn_next = $signed(32'h8000_0000);
        end else begin
            xn_next = diff[XW-1:0];
        end

        step_d   = $signed({xn_reg[XW-1], xn_reg}) - $signed({x_reg[XW-1], x_reg});
        step_mag = step_d[XW] ? (XW+1)'(-step_d) : (XW+1)'(step_d);

        sts.deriv_zero = (x_reg == $signed(32'h0000_8000));
        sts.quo_sat    = {3'b000, rem_reg} >= {den_reg, 1'b0};
        sts.step_small = step_mag < {2'b00, tolerance};

        root = cmd.sel_xn ? xn_reg : x_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= in_guess;
        end else if (cmd.commit) begin
            x_reg <= xn_reg;
        end
        if (cmd.mul) begin
            sq_reg <= x_reg * x_reg;
        end
        if (cmd.fx) begin
            rem_reg  <= fx_mag;
            den_reg  <= {fpx_mag, {(QW-1){1'b0}}};
            qneg_reg <= fx[SQW-1] ^ fpx[FPW-1];
        end
        if (cmd.sat_chk) begin
            q_reg <= sts.quo_sat ? {QW{1'b1}} : {QW{1'b0}};
        end else if (cmd.div_step) begin
            if (div_ge) begin
                rem_reg <= rem_reg - den_reg[SQW-1:0];
            end
            q_reg   <= {q_reg[QW-2:0], div_ge};
            den_reg <= den_reg >> 1;
        end
        if (cmd.upd) begin
            xn_reg <= xn_next;
        end
    end

endmodule

/* hw/rtl/nqrf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqrf_ctrl
// Sequencer for the Newton iteration, input handshake and result register.
// ----------------------------------------------------------------------------
module nqrf_ctrl #(
    parameter int MAX_ITER_LIMIT = nqrf_pkg::MAX_ITER_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nqrf_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic [nqrf_pkg::ITER_W-1:0]         max_iterations,
    input  nqrf_pkg::sts_t                      sts,
    input  logic signed [nqrf_pkg::XW-1:0]      root,
    output nqrf_pkg::cmd_t                      cmd
);

    localparam int IW  = nqrf_pkg::ITER_W;
    localparam int SW  = nqrf_pkg::STAT_W;
    localparam int CW  = $clog2(nqrf_pkg::QUO_W);

    localparam logic [2:0] IDLE  = 3'd0;
    localparam logic [2:0] START = 3'd1;
    localparam logic [2:0] FX    = 3'd2;
    localparam logic [2:0] SAT   = 3'd3;
    localparam logic [2:0] DIV   = 3'd4;
    localparam logic [2:0] UPD   = 3'd5;
    localparam logic [2:0] CHK   = 3'd6;
    localparam logic [2:0] DONE  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] used_reg, used_next;
    logic [SW-1:0] stat_reg, stat_next;
    logic          sel_xn_reg, sel_xn_next;
    logic          m_valid_reg, m_valid_next;
    logic [nqrf_pkg::RES_W-1:0] m_res_reg, m_res_next;
    logic [IW-1:0] limit;
    logic          out_free;

    assign limit = (MAX_ITER_LIMIT < int'(max_iterations)) ? IW'(MAX_ITER_LIMIT)
                                                           : max_iterations;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(nqrf_pkg::M_TDATA_W - nqrf_pkg::RES_W){1'b0}}, m_res_reg};

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        used_next    = used_reg;
        stat_next    = stat_reg;
        sel_xn_next  = sel_xn_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        cmd          = '0;
        cmd.sel_xn   = sel_xn_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    k_next     = '0;
                    state_next = START;
                end
            end
            START: begin
                cmd.mul = 1'b1;
                if (k_reg == limit) begin
                    used_next   = limit;
                    stat_next   = nqrf_pkg::ST_LIMIT;
                    sel_xn_next = 1'b0;
                    state_next  = DONE;
                end else if (sts.deriv_zero) begin
                    used_next   = k_reg + 1'b1;
                    stat_next   = nqrf_pkg::ST_DERIV_ZERO;
                    sel_xn_next = 1'b0;
                    state_next  = DONE;
                end else begin
                    state_next = FX;
                end
            end
            FX: begin
                cmd.fx     = 1'b1;
                state_next = SAT;
            end
            SAT: begin
                cmd.sat_chk = 1'b1;
                cnt_next    = CW'(nqrf_pkg::QUO_W - 1);
                state_next  = sts.quo_sat ? UPD : DIV;
            end
            DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = UPD;
                end
            end
            UPD: begin
                cmd.upd    = 1'b1;
                state_next = CHK;
            end
            CHK: begin
                if (sts.step_small) begin
                    used_next   = k_reg + 1'b1;
                    stat_next   = nqrf_pkg::ST_CONVERGED;
                    sel_xn_next = 1'b1;
                    state_next  = DONE;
                end else begin
                    cmd.commit = 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = START;
                end
            end
            DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = {stat_reg, used_reg, root};
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        used_reg   <= used_next;
        stat_reg   <= stat_next;
        sel_xn_reg <= sel_xn_next;
        m_res_reg  <= m_res_next;
    end

endmodule

/* hw/rtl/newton_quadratic_root_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_quadratic_root_finder
// Newton-Raphson root search on f(x) = x*x - x - 2 in signed Q16.16.
//
// s_ channel: one starting guess per item. m_ channel: one result per item
// (estimate, iterations used, status). cfg_ channel writes the tolerance
// (index 0) and the iteration limit (index 1); cfg_ready is always high.
// An item enters only while the block is idle; the next one is taken while
// the previous result still sits in the output register.
// Each Newton step: square, form f and f', overflow check, then the
// restoring divider at one quotient bit per cycle, then update and compare.
// A step whose quotient overflows skips the divider.
// The next item can be taken in the cycle in which m_tvalid rises.
// Reset clears the sequencer and the output valid and restores the
// register defaults (tolerance 66, limit 50). While m_tready is low a
// result holds; a finished run then waits before taking the next item.
// ----------------------------------------------------------------------------
module newton_quadratic_root_finder #(
    parameter int MAX_ITER_LIMIT = nqrf_pkg::MAX_ITER_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nqrf_pkg::S_TDATA_W-1:0]      s_tdata,   // initial_guess
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nqrf_pkg::M_TDATA_W-1:0]      m_tdata,   // root_estimate,
                                                           // iterations_used,
                                                           // status, zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nqrf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nqrf_pkg::CFG_DW-1:0]         cfg_data
);

    logic [nqrf_pkg::TOL_W-1:0]     tolerance;
    logic [nqrf_pkg::ITER_W-1:0]    max_iterations;
    nqrf_pkg::cmd_t                 cmd;
    nqrf_pkg::sts_t                 sts;
    logic signed [nqrf_pkg::XW-1:0] root;

    nqrf_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tolerance      (tolerance),
        .max_iterations (max_iterations)
    );

    nqrf_dp u_dp (
        .aclk      (aclk),
        .in_guess  ($signed(s_tdata[nqrf_pkg::XW-1:0])),
        .tolerance (tolerance),
        .cmd       (cmd),
        .sts       (sts),
        .root      (root)
    );

    nqrf_ctrl #(
        .MAX_ITER_LIMIT (MAX_ITER_LIMIT)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .max_iterations (max_iterations),
        .sts            (sts),
        .root           (root),
        .cmd            (cmd)
    );

endmodule

/* hw/rtl/nqrf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqrf_checker
// Port-level checks of the root finder, bound to the top level.
// ----------------------------------------------------------------------------
module nqrf_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [nqrf_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int RW = nqrf_pkg::RES_W;
    localparam int SL = nqrf_pkg::XW + nqrf_pkg::ITER_W;
    localparam int IL = nqrf_pkg::XW;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while a run is in progress");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[RW-1:SL] == nqrf_pkg::ST_CONVERGED
                  || m_tdata[RW-1:SL] == nqrf_pkg::ST_DERIV_ZERO
                  || m_tdata[RW-1:SL] == nqrf_pkg::ST_LIMIT)
        else $error("undefined status");

    a_iters: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RW-1:SL] != nqrf_pkg::ST_LIMIT |-> m_tdata[SL-1:IL] != '0)
        else $error("early stop reports zero iterations");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[nqrf_pkg::M_TDATA_W-1:RW] == '0)
        else $error("nonzero pad bits");

endmodule

bind newton_quadratic_root_finder nqrf_checker u_nqrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
